/* src/kle_pkg.sv */
// Shared types, command codes and scan-code key tables for the line editor.
package kle_pkg;

    localparam int KLE_LINE_DEPTH = 128;

    localparam logic [7:0] SC_BREAK  = 8'h80;
    localparam logic [7:0] SC_SHIFT_OFS = 8'd90;
    localparam logic [7:0] SC_LSHIFT = 8'd42;
    localparam logic [7:0] SC_RSHIFT = 8'd54;
    localparam logic [7:0] SC_CAPS   = 8'd58;
    localparam logic [7:0] SC_ENTER  = 8'd28;
    localparam logic [7:0] SC_BKSP   = 8'd14;
    localparam logic [7:0] SC_CTRL   = 8'd29;
    localparam logic [7:0] SC_L      = 8'd38;
    localparam logic [7:0] SC_MAKE_LAST = 8'd128;
    localparam logic [7:0] SC_BREAK_END = 8'd218;

    localparam int KEY_COUNT = 90;

    typedef enum logic [1:0] {
        CMD_SCAN  = 2'd0,
        CMD_TAKE  = 2'd1,
        CMD_FETCH = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    // decoded action of one scan code
    typedef struct packed {
        logic       set_ctrl;
        logic       clr_ctrl;
        logic       set_shift;
        logic       clr_shift;
        logic       toggle_caps;
        logic       clear_req;
        logic       backspace;
        logic       enter;
        logic       put;
        logic [7:0] ch;
    } t_key_act;

    localparam logic [7:0] KEY_PLAIN [0:KEY_COUNT-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] KEY_SHIFT [0:KEY_COUNT-1] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

/* src/kle_key_decode.sv */
// Scan-code decoder: modifier updates, special keys and ASCII mapping.
module kle_key_decode
    import kle_pkg::*;
(
    input  logic [7:0] i_key_code,
    input  logic       i_shift,
    input  logic       i_caps,
    input  logic       i_ctrl,
    output t_key_act   o_act
);

    logic       ignored;
    logic       is_make;
    logic       letter;
    logic       use_shift;
    logic [6:0] code;
    logic [7:0] sc;

    assign sc   = i_key_code;
    assign code = sc[6:0];

    assign ignored = (sc >= SC_SHIFT_OFS && sc <= SC_MAKE_LAST) || (sc >= SC_BREAK_END);
    assign is_make = !ignored && (sc < SC_BREAK);

    assign letter = (sc >= 8'd16 && sc <= 8'd25) || (sc >= 8'd30 && sc <= 8'd38) ||
                    (sc >= 8'd44 && sc <= 8'd50);

    // caps lock flips the table for letters only
    assign use_shift = (i_caps && letter) ? !i_shift : i_shift;

    always_comb begin
        o_act = '0;
        if (code < 7'(KEY_COUNT)) begin
            o_act.ch = use_shift ? KEY_SHIFT[code] : KEY_PLAIN[code];
        end
        if (is_make) begin
            if (sc == SC_CTRL) begin
                o_act.set_ctrl = 1'b1;
            end else if (sc == SC_L && i_ctrl) begin
                o_act.clear_req = 1'b1;
            end else if (sc == SC_BKSP) begin
                o_act.backspace = 1'b1;
            end else if (sc == SC_ENTER) begin
                o_act.enter = 1'b1;
            end else if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
                o_act.set_shift = 1'b1;
            end else if (sc == SC_CAPS) begin
                o_act.toggle_caps = 1'b1;
            end else begin
                o_act.put = 1'b1;
            end
        end else if (!ignored) begin
            if (sc == (SC_LSHIFT | SC_BREAK) || sc == (SC_RSHIFT | SC_BREAK)) begin
                o_act.clr_shift = 1'b1;
            end else if (sc == (SC_CTRL | SC_BREAK)) begin
                o_act.clr_ctrl = 1'b1;
            end
        end
    end

endmodule

/* src/kle_line_ram.sv */
// Line buffer: single write port, one registered read port.
module kle_line_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/keyboard_scancode_line_editor_core.sv */
// Line editor top: modifier and fill state, buffer access, result register.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+---------------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready  | tuser: cmd; tdata: key_code, req_count, pos
//  m       | out | o_m_tvalid / i_m_tready  | tdata: echo, char, erase, clr, ready, len,
//          |     |                          |        read_byte, status
//
// One transaction per cycle while o_s_tready is high; its result is registered
// and appears in the cycle after acceptance. All state updates happen at the
// accepting edge; fetch data comes from the buffer's registered read port.
// o_s_tready is high whenever the result register is empty or being drained.
// Synchronous active-low reset clears modifiers, fill count and line flag;
// buffer contents are not cleared.
module keyboard_scancode_line_editor_core
    import kle_pkg::*;
#(
    parameter int LINE_DEPTH = KLE_LINE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // [7:0] key_code, [15:8] req_count, [22:16] position
    input  logic [1:0]  i_s_tuser,  // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] echo_valid, [8:1] echo_char, [9] erase_echo, [10] clear_screen,
    // [11] line_ready, [19:12] line_length, [27:20] read_byte, [28] status
    output logic [31:0] o_m_tdata
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam int MW = (FW > 8) ? FW : 8;
    localparam int PW = (AW > 7) ? AW : 7;

    typedef struct packed {
        logic       status;
        logic [7:0] line_length;
        logic       line_ready;
        logic       clear_screen;
        logic       erase_echo;
        logic [7:0] echo_char;
        logic       echo_valid;
    } t_result;

    logic          accept;
    t_cmd          cmd;
    logic [7:0]    key_code;
    logic [7:0]    req_count;
    logic [6:0]    position;
    t_key_act      act;

    logic [FW-1:0] r_fill, n_fill;
    logic          r_done, n_done;
    logic          r_shift, n_shift;
    logic          r_caps, n_caps;
    logic          r_ctrl, n_ctrl;
    logic          r_out_valid;
    t_result       r_res, n_res;
    logic          r_fetch_ok, n_fetch_ok;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] pos_ext;
    logic [MW-1:0] req_ext;
    logic [MW-1:0] fill_ext;
    logic [MW-1:0] grant;
    logic          room;
    logic [7:0]    rd_data;

    assign accept    = i_s_tvalid && o_s_tready;
    assign cmd       = t_cmd'(i_s_tuser);
    assign key_code  = i_s_tdata[7:0];
    assign req_count = i_s_tdata[15:8];
    assign position  = i_s_tdata[22:16];

    assign o_s_tready = !r_out_valid || i_m_tready;

    assign pos_ext  = PW'(position);
    assign rd_addr  = pos_ext[AW-1:0];
    assign req_ext  = MW'(req_count);
    assign fill_ext = MW'(r_fill);
    assign grant    = (req_ext < fill_ext) ? req_ext : fill_ext;

    kle_key_decode u_decode (
        .i_key_code  (key_code),
        .i_shift     (r_shift),
        .i_caps      (r_caps),
        .i_ctrl      (r_ctrl),
        .o_act       (act)
    );

    // store allowed: line open, nonzero mapping, slot free (last slot kept for enter)
    assign room = !r_done && (act.ch != 8'h00) && (r_fill < FW'(LINE_DEPTH)) &&
                  (act.enter || (r_fill < FW'(LINE_DEPTH - 1)));

    always_comb begin
        n_fill     = r_fill;
        n_done     = r_done;
        n_shift    = r_shift;
        n_caps     = r_caps;
        n_ctrl     = r_ctrl;
        n_res      = '0;
        n_fetch_ok = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (cmd)
            CMD_SCAN: begin
                if (act.set_ctrl) begin
                    n_ctrl = 1'b1;
                end
                if (act.clr_ctrl) begin
                    n_ctrl = 1'b0;
                end
                if (act.set_shift) begin
                    n_shift = 1'b1;
                end
                if (act.clr_shift) begin
                    n_shift = 1'b0;
                end
                if (act.toggle_caps) begin
                    n_caps = !r_caps;
                end
                n_res.clear_screen = act.clear_req;
                if (act.backspace && r_fill != '0) begin
                    n_fill           = r_fill - FW'(1);
                    n_res.erase_echo = 1'b1;
                end
                if ((act.put || act.enter) && room) begin
                    wr_en            = accept;
                    n_fill           = r_fill + FW'(1);
                    n_res.echo_valid = 1'b1;
                    n_res.echo_char  = act.ch;
                end
                if (act.enter) begin
                    n_done = 1'b1;
                end
            end
            CMD_TAKE: begin
                if (r_done) begin
                    n_res.line_length = grant[7:0];
                    n_fill            = '0;
                    n_done            = 1'b0;
                end else begin
                    n_res.status = 1'b1;
                end
            end
            CMD_FETCH: begin
                rd_en      = accept;
                n_fetch_ok = (32'(position) < 32'(LINE_DEPTH));
            end
            CMD_RESET: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
        n_res.line_ready = n_done;
    end

    kle_line_ram #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (act.ch),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_done      <= 1'b0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
            r_ctrl      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill  <= n_fill;
                r_done  <= n_done;
                r_shift <= n_shift;
                r_caps  <= n_caps;
                r_ctrl  <= n_ctrl;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res      <= n_res;
            r_fetch_ok <= n_fetch_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_res.status, (r_fetch_ok ? rd_data : 8'h00),
                         r_res.line_length, r_res.line_ready, r_res.clear_screen,
                         r_res.erase_echo, r_res.echo_char, r_res.echo_valid};

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_DEPTH))
        else $error("fill count beyond line depth");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty result register");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_tvalid)
        else $error("accepted transaction produced no result");

    a_take_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_TAKE && r_done) |=> (r_fill == '0 && !r_done))
        else $error("take line did not empty the line");

    a_done_blocks_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && wr_en) |-> 1'b0)
        else $error("buffer written while line is complete");
`endif

endmodule
